FILE: hw/rtl/nibble_alu_with_flags_macros.svh
// Assertion macros used by the nibble ALU top level.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef NIBBLE_ALU_WITH_FLAGS_MACROS_SVH
`define NIBBLE_ALU_WITH_FLAGS_MACROS_SVH

`ifndef SYNTH

`define NALU_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nalu: same-cycle check failed");

`define NALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nalu: next-cycle check failed");

`else

`define NALU_ASSERT_IMPLIES(label, ante, cons)

`define NALU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/nalu_pkg.sv
// Types, opcodes and table helpers for the nibble ALU.
// No dependencies; used by the interfaces and all RTL modules.
`timescale 1ns / 1ps

package nalu_pkg;

    typedef logic [3:0] nibble_t;

    typedef enum logic [3:0] {
        OP_PASS_B = 4'd0,
        OP_NOT_A  = 4'd1,
        OP_AND    = 4'd2,
        OP_OR     = 4'd3,
        OP_XOR    = 4'd4,
        OP_SHL    = 4'd5,
        OP_SHR    = 4'd6,
        OP_INC    = 4'd7,
        OP_DEC    = 4'd8,
        OP_ADD    = 4'd9,
        OP_ADC    = 4'd10,
        OP_SUB    = 4'd11,
        OP_SBB    = 4'd12,
        OP_MUL_LO = 4'd13,
        OP_MUL_HI = 4'd14,
        OP_DIV    = 4'd15
    } op_t;

    localparam int TBL_AW    = 8;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    localparam logic [7:0] CARRY_BIT = 8'b0001_0000;
    localparam logic [7:0] SIGN_BIT  = 8'b0000_1000;

    // One table entry per operand pair: full product and quotient.
    typedef struct packed {
        logic [7:0] product;
        nibble_t    quotient;
    } tbl_entry_t;

    function automatic tbl_entry_t tbl_calc(input nibble_t a, input nibble_t b);
        tbl_entry_t e;
        logic [4:0] rem;
        nibble_t    q;
        e.product = {4'b0000, a} * {4'b0000, b};
        rem = '0;
        q   = '0;
        // restoring division, one quotient bit per step
        for (int i = 3; i >= 0; i--)
        begin
            rem = {rem[3:0], a[i]};
            if (rem >= {1'b0, b})
            begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        // divide by zero yields zero
        if (b == 4'd0)
        begin
            q = '0;
        end
        e.quotient = q;
        return e;
    endfunction

endpackage

FILE: hw/rtl/nalu_if.sv
// Request and response channel interfaces for the nibble ALU.
// Depends on nalu_pkg for the nibble type.
`timescale 1ns / 1ps

interface nalu_req_if;
    import nalu_pkg::*;

    logic    valid;
    logic    ready;
    nibble_t operation;
    nibble_t operand_a;
    nibble_t operand_b;
    logic    carry_in;

    modport source (output valid, output operation, output operand_a,
                    output operand_b, output carry_in, input ready);
    modport sink   (input valid, input operation, input operand_a,
                    input operand_b, input carry_in, output ready);
endinterface

interface nalu_rsp_if;
    import nalu_pkg::*;

    logic    valid;
    logic    ready;
    nibble_t result;
    logic    carry_out;
    logic    zero_flag;
    logic    overflow_flag;
    logic    equal_flag;

    modport source (output valid, output result, output carry_out, output zero_flag,
                    output overflow_flag, output equal_flag, input ready);
    modport sink   (input valid, input result, input carry_out, input zero_flag,
                    input overflow_flag, input equal_flag, output ready);
endinterface

FILE: hw/rtl/nalu_table.sv
// Product/quotient lookup memory with a load sweep after reset.
// Depends on nalu_pkg; read data is registered.
`timescale 1ns / 1ps

module nalu_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [nalu_pkg::TBL_AW-1:0]   rd_addr,
    output nalu_pkg::tbl_entry_t          rd_data,
    output logic                          fill_done
);
    import nalu_pkg::*;

    tbl_entry_t        tbl_mem [TBL_DEPTH];
    tbl_entry_t        rd_data_reg;
    logic [TBL_AW:0]   fill_idx_reg;
    logic [TBL_AW:0]   fill_idx_next;
    tbl_entry_t        fill_entry;

    assign fill_done = fill_idx_reg[TBL_AW];

    always_comb
    begin
        fill_idx_next = fill_idx_reg;
        if (!fill_done)
        begin
            fill_idx_next = fill_idx_reg + 1'b1;
        end
        fill_entry = tbl_calc(fill_idx_reg[TBL_AW-1:TBL_AW/2],
                              fill_idx_reg[TBL_AW/2-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg <= '0;
        end
        else
        begin
            fill_idx_reg <= fill_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!fill_done)
        begin
            tbl_mem[fill_idx_reg[TBL_AW-1:0]] <= fill_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/nibble_alu_with_flags.sv
// Nibble ALU top level: 16 ops, result plus carry, zero, overflow and equal flags.
// Pipeline: accept loads stage 1 and the table read register; the result register holds the response.
// Throughput: one word per cycle while response.ready is high; the table memory read port sets the first stage.
// Reset: pipeline empties; a sweep over all 256 entries then loads the product/quotient table,
// and request.ready stays low until it completes.
`timescale 1ns / 1ps

module nibble_alu_with_flags (
    input  logic       clk,
    input  logic       rst_n,
    nalu_req_if.sink   request,
    nalu_rsp_if.source response
);
    import nalu_pkg::*;
    `include "nibble_alu_with_flags_macros.svh"

    logic       fill_done;
    tbl_entry_t tbl_data;
    logic       accept;
    logic       advance;

    logic       s1_valid_reg;
    op_t        s1_op_reg;
    nibble_t    s1_a_reg;
    nibble_t    s1_b_reg;
    logic       s1_ci_reg;

    logic       out_valid_reg;
    nibble_t    out_result_reg;
    logic       out_carry_reg;
    logic       out_zero_reg;
    logic       out_ovf_reg;
    logic       out_equal_reg;

    logic [7:0] a_ext;
    logic [7:0] b_ext;
    logic [7:0] ci_ext;
    logic [7:0] wide;
    nibble_t    res_next;
    logic       is_arith;
    logic       is_sub;
    logic       carry_next;
    logic       ovf_next;

    // stage 1 drains into the output register whenever it is free or being read
    assign advance       = !out_valid_reg || response.ready;
    assign request.ready = fill_done && (!s1_valid_reg || advance);
    assign accept        = request.valid && request.ready;

    nalu_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   ({request.operand_a, request.operand_b}),
        .rd_data   (tbl_data),
        .fill_done (fill_done)
    );

    always_comb
    begin
        a_ext    = {4'b0000, s1_a_reg};
        b_ext    = {4'b0000, s1_b_reg};
        ci_ext   = {7'b0000000, s1_ci_reg};
        wide     = 8'd0;
        res_next = 4'd0;
        is_arith = 1'b0;
        is_sub   = 1'b0;
        case (s1_op_reg)
            OP_PASS_B: res_next = s1_b_reg;
            OP_NOT_A:  res_next = ~s1_a_reg;
            OP_AND:    res_next = s1_a_reg & s1_b_reg;
            OP_OR:     res_next = s1_a_reg | s1_b_reg;
            OP_XOR:    res_next = s1_a_reg ^ s1_b_reg;
            OP_SHL:    res_next = (s1_b_reg[3:2] == 2'b00) ? (s1_a_reg << s1_b_reg[1:0]) : 4'd0;
            OP_SHR:    res_next = (s1_b_reg[3:2] == 2'b00) ? (s1_a_reg >> s1_b_reg[1:0]) : 4'd0;
            OP_INC:
            begin
                is_arith = 1'b1;
                wide     = a_ext + 8'd1;
            end
            OP_DEC:
            begin
                is_arith = 1'b1;
                is_sub   = 1'b1;
                wide     = a_ext - 8'd1;
            end
            OP_ADD:
            begin
                is_arith = 1'b1;
                wide     = a_ext + b_ext;
            end
            OP_ADC:
            begin
                is_arith = 1'b1;
                wide     = a_ext + b_ext + ci_ext;
            end
            OP_SUB:
            begin
                is_arith = 1'b1;
                is_sub   = 1'b1;
                wide     = a_ext - b_ext;
            end
            OP_SBB:
            begin
                is_arith = 1'b1;
                is_sub   = 1'b1;
                wide     = a_ext - b_ext - ci_ext;
            end
            OP_MUL_LO: res_next = tbl_data.product[3:0];
            OP_MUL_HI: res_next = tbl_data.product[7:4];
            OP_DIV:    res_next = tbl_data.quotient;
            default:   res_next = 4'd0;
        endcase
        if (is_arith)
        begin
            res_next = wide[3:0];
        end
        carry_next = is_arith && ((wide & CARRY_BIT) != 8'd0);
        // bit 3 rule: add sets it from a clear sign, subtract clears it from a set sign
        if (is_sub)
        begin
            ovf_next = is_arith && ((wide & SIGN_BIT) == 8'd0) && s1_a_reg[3];
        end
        else
        begin
            ovf_next = is_arith && ((wide & SIGN_BIT) != 8'd0) && !s1_a_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= op_t'(request.operation);
            s1_a_reg  <= request.operand_a;
            s1_b_reg  <= request.operand_b;
            s1_ci_reg <= request.carry_in;
        end
        if (advance && s1_valid_reg)
        begin
            out_result_reg <= res_next;
            out_carry_reg  <= carry_next;
            out_zero_reg   <= (res_next == 4'd0);
            out_ovf_reg    <= ovf_next;
            out_equal_reg  <= (s1_a_reg == s1_b_reg);
        end
    end

    assign response.valid         = out_valid_reg;
    assign response.result        = out_result_reg;
    assign response.carry_out     = out_carry_reg;
    assign response.zero_flag     = out_zero_reg;
    assign response.overflow_flag = out_ovf_reg;
    assign response.equal_flag    = out_equal_reg;

    `NALU_ASSERT_IMPLIES(a_no_accept_in_fill, request.valid && request.ready, fill_done)
    `NALU_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_reg && !advance, s1_valid_reg)
    `NALU_ASSERT_NEXT(a_s1_lands_in_out, s1_valid_reg && advance, out_valid_reg)
    `NALU_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg)

endmodule
